### hdl/mbe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 28;

    localparam int COORD_W  = 12;
    localparam int DATA_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int THRESH_W = 31;
    localparam int INDEX_W  = 3;
    localparam int OUT_W    = 16;

    typedef logic [COUNT_BITS-1:0] count_t;

    // Largest count that the counter can hold, kept one bit wider than any counter.
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    localparam logic signed [DATA_W-1:0] RST_ORIGIN_REAL = -32'sd536870912;
    localparam logic signed [DATA_W-1:0] RST_ORIGIN_IMAG = -32'sd402653184;
    localparam logic signed [DATA_W-1:0] RST_STEP_REAL   = 32'sd196608;
    localparam logic signed [DATA_W-1:0] RST_STEP_IMAG   = 32'sd196608;
    localparam logic [LIMIT_W-1:0]       RST_LIMIT       = 16'd256;
    localparam logic [THRESH_W-1:0]      RST_THRESHOLD   = 31'd1073741824;

    typedef enum logic [INDEX_W-1:0] {
        REG_ORIGIN_REAL      = 3'd0,
        REG_ORIGIN_IMAG      = 3'd1,
        REG_STEP_REAL        = 3'd2,
        REG_STEP_IMAG        = 3'd3,
        REG_ITERATION_LIMIT  = 3'd4,
        REG_ESCAPE_THRESHOLD = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_real;
        logic signed [DATA_W-1:0] origin_imag;
        logic signed [DATA_W-1:0] step_real;
        logic signed [DATA_W-1:0] step_imag;
        logic [LIMIT_W-1:0]       iteration_limit;
        logic [THRESH_W-1:0]      escape_threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CR,
        ST_CI,
        ST_CI_ADD,
        ST_RR,
        ST_II,
        ST_RI,
        ST_UPD
    } state_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/mbe_pix_if.sv
// Pixel coordinate channel: valid/ready handshake with column and row.
// Depends on mbe_pkg for the coordinate width.
`timescale 1ns / 1ps

interface mbe_pix_if;
    logic                           valid;
    logic                           ready;
    logic [mbe_pkg::COORD_W-1:0]    column;
    logic [mbe_pkg::COORD_W-1:0]    row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

### hdl/mbe_res_if.sv
// Result channel: valid/ready handshake with iteration count and limit flag.
// Depends on mbe_pkg for the count width.
`timescale 1ns / 1ps

interface mbe_res_if;
    logic                        valid;
    logic                        ready;
    logic [mbe_pkg::OUT_W-1:0]   iteration_count;
    logic                        reached_limit;

    modport source (output valid, output iteration_count, output reached_limit, input ready);
    modport sink   (input valid, input iteration_count, input reached_limit, output ready);
endinterface

### hdl/mbe_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on mbe_pkg for index and data widths.
`timescale 1ns / 1ps

interface mbe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mbe_pkg::INDEX_W-1:0]   index;
    logic [mbe_pkg::DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/mbe_regfile.sv
// Configuration register file of the escape-time block.
// Depends on mbe_pkg and mbe_cfg_if.
`timescale 1ns / 1ps

module mbe_regfile
(
    input  logic            clk,
    input  logic            rst_n,
    mbe_cfg_if.sink         cfg,
    output mbe_pkg::cfg_t   regs
);

    mbe_pkg::cfg_t cfg_reg;
    mbe_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mbe_pkg::REG_ORIGIN_REAL:      cfg_next.origin_real = cfg.data;
                mbe_pkg::REG_ORIGIN_IMAG:      cfg_next.origin_imag = cfg.data;
                mbe_pkg::REG_STEP_REAL:        cfg_next.step_real   = cfg.data;
                mbe_pkg::REG_STEP_IMAG:        cfg_next.step_imag   = cfg.data;
                mbe_pkg::REG_ITERATION_LIMIT:
                    cfg_next.iteration_limit = cfg.data[mbe_pkg::LIMIT_W-1:0];
                mbe_pkg::REG_ESCAPE_THRESHOLD:
                    cfg_next.escape_threshold = cfg.data[mbe_pkg::THRESH_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_real      <= mbe_pkg::RST_ORIGIN_REAL;
            cfg_reg.origin_imag      <= mbe_pkg::RST_ORIGIN_IMAG;
            cfg_reg.step_real        <= mbe_pkg::RST_STEP_REAL;
            cfg_reg.step_imag        <= mbe_pkg::RST_STEP_IMAG;
            cfg_reg.iteration_limit  <= mbe_pkg::RST_LIMIT;
            cfg_reg.escape_threshold <= mbe_pkg::RST_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/mbe_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbe_pkg for the operand width.
`timescale 1ns / 1ps

module mbe_mul
(
    input  logic                                clk,
    input  logic signed [mbe_pkg::DATA_W-1:0]   a,
    input  logic signed [mbe_pkg::DATA_W-1:0]   b,
    output logic signed [2*mbe_pkg::DATA_W-1:0] prod
);

    logic signed [2*mbe_pkg::DATA_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

### hdl/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time block: sequencer around one shared multiplier.
// Depends on mbe_pkg, the three channel interfaces, mbe_regfile and mbe_mul.
`timescale 1ns / 1ps

// Usage
//   pix : pixel coordinate (column, row); one transfer starts one pixel.
//   res : one transfer per pixel with iteration_count and reached_limit.
//   cfg : register writes (index 0..5); always ready. Write only while idle.
// Timing
//   The block works on one pixel at a time. pix.ready is high only in the
//   idle state. A single 32x32 multiplier is shared by every product, so
//   the point c is formed in ST_CR, ST_CI and ST_CI_ADD, and each pass of
//   the loop runs ST_RR, ST_II and ST_RI (two squares and one product), then
//   ST_UPD (one add/saturate/compare step). A pixel that runs n iterations
//   makes n + 1 passes, the last one only for the exit check; the default
//   limit is 256. res.valid rises as the sequencer returns to idle, so the
//   next pixel can transfer in the cycle that res.valid rises.
// Stalls
//   The result sits in an output register. A new pixel may be accepted while
//   the previous result waits; if that pixel finishes before the result is
//   taken, the sequencer holds in its final step until res.ready.
// Reset
//   rst_n clears the sequencer and the output valid flag and restores the
//   default view registers (origin -2.0 - 1.5i, step 3/4096, limit 256,
//   threshold 4.0). No clearing pass is needed.

module mandelbrot_escape_time
(
    input  logic      clk,
    input  logic      rst_n,
    mbe_pix_if.sink   pix,
    mbe_res_if.source res,
    mbe_cfg_if.sink   cfg
);

    localparam int W  = mbe_pkg::DATA_W;
    localparam int SW = 38;  // width of the per-iteration sums

    mbe_pkg::cfg_t   regs;
    mbe_pkg::state_t state_reg, state_next;

    logic [mbe_pkg::COORD_W-1:0] col_reg, col_next;
    logic [mbe_pkg::COORD_W-1:0] row_reg, row_next;
    logic signed [W-1:0]         cr_reg, cr_next;
    logic signed [W-1:0]         ci_reg, ci_next;
    logic signed [W-1:0]         zr_reg, zr_next;
    logic signed [W-1:0]         zi_reg, zi_next;
    logic signed [35:0]          rr_reg, rr_next;
    logic signed [35:0]          ii_reg, ii_next;
    mbe_pkg::count_t             k_reg, k_next;

    logic                        res_valid_reg, res_valid_next;
    logic [mbe_pkg::OUT_W-1:0]   res_count_reg, res_count_next;
    logic                        res_reached_reg, res_reached_next;

    logic signed [W-1:0]   mul_a, mul_b;
    logic signed [2*W-1:0] prod;

    logic [W-1:0]          col_ext, row_ext;
    logic [W-1:0]          col_idx, row_idx;
    mbe_pkg::count_t       eff_limit;
    logic signed [2*W-1:0] prod_q28, prod_q27;
    logic signed [SW-1:0]  zr_sum, zi_sum;
    logic [36:0]           mag_sum;
    logic [mbe_pkg::THRESH_W-1:0] mag;
    logic                  at_limit, escaped, finish;
    logic                  pix_fire, res_fire;

    mbe_regfile u_regfile
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mbe_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign pix.ready           = (state_reg == mbe_pkg::ST_IDLE);
    assign pix_fire            = pix.valid && pix.ready;
    assign res.valid           = res_valid_reg;
    assign res.iteration_count = res_count_reg;
    assign res.reached_limit   = res_reached_reg;
    assign res_fire            = res.valid && res.ready;

    // Clamp coordinates beyond the picture to its last column or row.
    assign col_ext = {{(W-mbe_pkg::COORD_W){1'b0}}, col_reg};
    assign row_ext = {{(W-mbe_pkg::COORD_W){1'b0}}, row_reg};
    assign col_idx = (col_ext >= W'(mbe_pkg::MAX_COLUMNS)) ? W'(mbe_pkg::MAX_COLUMNS - 1) : col_ext;
    assign row_idx = (row_ext >= W'(mbe_pkg::MAX_ROWS)) ? W'(mbe_pkg::MAX_ROWS - 1) : row_ext;

    // The counter width caps the limit.
    assign eff_limit = (33'(regs.iteration_limit) > mbe_pkg::COUNT_MAX)
                     ? mbe_pkg::count_t'(mbe_pkg::COUNT_MAX)
                     : mbe_pkg::count_t'(regs.iteration_limit);

    // Floor shifts: arithmetic shift of the product rounds toward minus infinity.
    assign prod_q28 = prod >>> mbe_pkg::FRAC_BITS;
    assign prod_q27 = prod >>> (mbe_pkg::FRAC_BITS - 1);

    // Final step of an iteration: prod holds zr*zi here.
    assign zr_sum  = SW'(rr_reg) - SW'(ii_reg) + SW'(cr_reg);
    assign zi_sum  = prod_q27[SW-1:0] + SW'(ci_reg);
    assign mag_sum = 37'(rr_reg[34:0]) + 37'(ii_reg[34:0]);  // both squares are >= 0
    assign mag     = (mag_sum > 37'h7FFFFFFF) ? 31'h7FFFFFFF : mag_sum[30:0];
    assign at_limit = (k_reg >= eff_limit);
    assign escaped  = (mag >= regs.escape_threshold);
    assign finish   = at_limit || escaped;

    // Operand select for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            mbe_pkg::ST_CR:
            begin
                mul_a = col_idx;
                mul_b = regs.step_real;
            end
            mbe_pkg::ST_CI:
            begin
                mul_a = row_idx;
                mul_b = regs.step_imag;
            end
            mbe_pkg::ST_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            mbe_pkg::ST_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    // Sequencer: next state and datapath register updates.
    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        cr_next          = cr_reg;
        ci_next          = ci_reg;
        zr_next          = zr_reg;
        zi_next          = zi_reg;
        rr_next          = rr_reg;
        ii_next          = ii_reg;
        k_next           = k_reg;
        res_count_next   = res_count_reg;
        res_reached_next = res_reached_reg;
        // Drop the valid flag once the result is taken.
        res_valid_next   = res_valid_reg && !res.ready;

        case (state_reg)
            mbe_pkg::ST_IDLE:
            begin
                if (pix_fire)
                begin
                    col_next   = pix.column;
                    row_next   = pix.row;
                    state_next = mbe_pkg::ST_CR;
                end
            end
            mbe_pkg::ST_CR:
            begin
                state_next = mbe_pkg::ST_CI;
            end
            mbe_pkg::ST_CI:
            begin
                cr_next    = mbe_pkg::sat32(64'(regs.origin_real) + prod);
                state_next = mbe_pkg::ST_CI_ADD;
            end
            mbe_pkg::ST_CI_ADD:
            begin
                ci_next    = mbe_pkg::sat32(64'(regs.origin_imag) + prod);
                zr_next    = '0;
                zi_next    = '0;
                k_next     = '0;
                state_next = mbe_pkg::ST_RR;
            end
            mbe_pkg::ST_RR:
            begin
                state_next = mbe_pkg::ST_II;
            end
            mbe_pkg::ST_II:
            begin
                rr_next    = prod_q28[35:0];
                state_next = mbe_pkg::ST_RI;
            end
            mbe_pkg::ST_RI:
            begin
                ii_next    = prod_q28[35:0];
                state_next = mbe_pkg::ST_UPD;
            end
            mbe_pkg::ST_UPD:
            begin
                if (finish)
                begin
                    // Hold here while an older result still waits.
                    if (!res_valid_reg || res.ready)
                    begin
                        res_valid_next   = 1'b1;
                        res_count_next   = mbe_pkg::OUT_W'(32'(k_reg));
                        res_reached_next = at_limit;
                        state_next       = mbe_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    zr_next    = mbe_pkg::sat32(64'(zr_sum));
                    zi_next    = mbe_pkg::sat32(64'(zi_sum));
                    k_next     = k_reg + 1'b1;
                    state_next = mbe_pkg::ST_RR;
                end
            end
            default:
            begin
                state_next = mbe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbe_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg         <= col_next;
        row_reg         <= row_next;
        cr_reg          <= cr_next;
        ci_reg          <= ci_next;
        zr_reg          <= zr_next;
        zi_reg          <= zi_next;
        rr_reg          <= rr_next;
        ii_reg          <= ii_next;
        k_reg           <= k_next;
        res_count_reg   <= res_count_next;
        res_reached_reg <= res_reached_next;
    end

    // A pixel transfer always starts the coordinate step.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire |=> (state_reg == mbe_pkg::ST_CR))
        else $error("pixel transfer did not start the sequencer");

    // The counter never passes the effective limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbe_pkg::ST_UPD) |-> (k_reg <= eff_limit))
        else $error("iteration counter beyond limit");

    // A new result appears only from the final iteration step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == mbe_pkg::ST_UPD))
        else $error("result raised outside the final step");

    // A limit-flagged result carries the limit as its count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reached_reg)
            |-> (res_count_reg == mbe_pkg::OUT_W'(32'(eff_limit))))
        else $error("limit flag without count at limit");

    // A finished result is never overwritten while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready) |=> (res_valid_reg && $stable(res_count_reg)))
        else $error("pending result lost");

endmodule
